// ===== rtl/lpt_pkg.sv =====
// Shared types and constants for the linear page table translator.
package lpt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int PPN_BITS    = 16;
  localparam int ADDR_BITS   = 32;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [15:0] PPN_MASK  = 16'((64'd1 << PPN_BITS) - 64'd1);

  localparam logic [4:0] SHIFT_MIN   = 5'd4;
  localparam logic [4:0] SHIFT_MAX   = 5'd16;
  localparam logic [4:0] SHIFT_RESET = 5'd7;

  // Request codes.
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_LOAD      = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ADDR_ERR  = 3'd1;
  localparam logic [2:0] ST_READ_ONLY = 3'd2;
  localparam logic [2:0] ST_PAGE_FLT  = 3'd3;
  localparam logic [2:0] ST_BUS_ERR   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PAGE_SHIFT = 2'd0;
  localparam logic [1:0] CFG_TABLE_PGS  = 2'd1;
  localparam logic [1:0] CFG_PHYS_PGS   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] virt_addr;
    logic        is_write;
    logic [7:0]  entry_index;
    logic [15:0] entry_ppn;
    logic        entry_read_ok;
    logic        entry_write_ok;
    logic        entry_valid;
    logic        entry_used;
    logic        entry_modified;
  } lpt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] phys_addr;
    logic [15:0] out_ppn;
    logic        out_read_ok;
    logic        out_write_ok;
    logic        out_valid;
    logic        out_used;
    logic        out_modified;
  } lpt_out_t;

  typedef struct packed {
    logic [15:0] ppn;
    logic        read_ok;
    logic        write_ok;
    logic        valid;
    logic        used;
    logic        modified;
  } lpt_entry_t;

endpackage

// ===== rtl/linear_page_table_translator_top.sv =====
// Linear page table translator: table RAM, rights checks and result register.
//
// The block accepts one beat every cycle while the result side keeps up. A
// beat passes through the registered read of the page table RAM and then
// the check and update logic feeding the result register. The table has one
// entry per virtual page in a single-port-write RAM; a flip-flop per entry
// marks it as written, so an entry never loaded reads as zero right after
// reset with no clearing pass. A translate that hits writes the used and
// modified bits back from the check and update logic, and that write is
// forwarded to the next beat if it reads the same entry. Configuration writes
// are taken at any time but must only be issued while no beat is in flight.
module linear_page_table_translator_top
  import lpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  lpt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output lpt_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [4:0]  page_shift_r;
  logic [8:0]  table_pages_r;
  logic [15:0] num_phys_r;

  // First stage: accepted beat plus registered table read.
  logic             p_v_r;
  lpt_in_t          p_item_r;
  logic [IDX_W-1:0] p_addr_r;
  logic             p_in_range_r;
  logic             p_idx_ok_r;
  lpt_entry_t       mem_q_r;
  logic             vld_hit_r;
  logic             fwd_r;
  lpt_entry_t       fwd_data_r;

  // Result register.
  logic     out_v_r;
  lpt_out_t out_data_r;

  lpt_entry_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;

  logic [4:0]       sh_eff;
  logic [31:0]      va_in;
  logic [31:0]      vpn_in;
  logic [31:0]      limit;
  logic [31:0]      idx_in;
  logic [IDX_W-1:0] rd_addr;
  logic             out_adv;
  logic             p_load;

  logic             wen;
  lpt_entry_t       wdata;
  lpt_entry_t       entry;
  lpt_out_t         res;
  logic [31:0]      va_p;
  logic [31:0]      off_p;

  always_comb begin
    if (page_shift_r < SHIFT_MIN) begin
      sh_eff = SHIFT_MIN;
    end else if (page_shift_r > SHIFT_MAX) begin
      sh_eff = SHIFT_MAX;
    end else begin
      sh_eff = page_shift_r;
    end
  end

  assign va_in  = in_data.virt_addr & ADDR_MASK;
  assign vpn_in = va_in >> sh_eff;
  assign limit  = (32'(table_pages_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                           : 32'(table_pages_r);
  assign idx_in = 32'(in_data.entry_index);
  assign rd_addr = (in_data.op == OP_TRANSLATE) ? vpn_in[IDX_W-1:0] : idx_in[IDX_W-1:0];

  assign out_adv  = !out_v_r || !out_stall;
  assign p_load   = !p_v_r || out_adv;
  assign in_stall = !p_load;

  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r  <= SHIFT_RESET;
      table_pages_r <= '0;
      num_phys_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAGE_SHIFT: page_shift_r  <= cfg_wdata[4:0];
        CFG_TABLE_PGS:  table_pages_r <= cfg_wdata[8:0];
        CFG_PHYS_PGS:   num_phys_r    <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Check and update logic, feeding the result register.
  always_comb begin
    entry = fwd_r ? fwd_data_r : (vld_hit_r ? mem_q_r : '0);
    va_p  = p_item_r.virt_addr & ADDR_MASK;
    off_p = va_p & ((32'd1 << sh_eff) - 32'd1);
    res   = '0;
    wen   = 1'b0;
    wdata = entry;
    case (p_item_r.op)
      OP_TRANSLATE: begin
        if (!p_in_range_r) begin
          res.status = ST_ADDR_ERR;
        end else if (!entry.read_ok && !entry.write_ok) begin
          res.status = ST_ADDR_ERR;
        end else if (p_item_r.is_write && !entry.write_ok) begin
          res.status = ST_READ_ONLY;
        end else if (!entry.valid) begin
          res.status = ST_PAGE_FLT;
        end else if (entry.ppn >= num_phys_r) begin
          res.status = ST_BUS_ERR;
        end else begin
          res.status     = ST_OK;
          res.phys_addr  = ((32'(entry.ppn) << sh_eff) | off_p) & ADDR_MASK;
          wen            = 1'b1;
          wdata.used     = 1'b1;
          wdata.modified = entry.modified | p_item_r.is_write;
        end
      end
      OP_LOAD: begin
        res.status     = ST_OK;
        wen            = p_idx_ok_r;
        wdata.ppn      = p_item_r.entry_ppn & PPN_MASK;
        wdata.read_ok  = p_item_r.entry_read_ok;
        wdata.write_ok = p_item_r.entry_write_ok;
        wdata.valid    = p_item_r.entry_valid;
        wdata.used     = p_item_r.entry_used;
        wdata.modified = p_item_r.entry_modified;
      end
      OP_READ: begin
        if (p_idx_ok_r) begin
          res.status       = ST_OK;
          res.out_ppn      = entry.ppn;
          res.out_read_ok  = entry.read_ok;
          res.out_write_ok = entry.write_ok;
          res.out_valid    = entry.valid;
          res.out_used     = entry.used;
          res.out_modified = entry.modified;
        end else begin
          res.status = ST_ADDR_ERR;
        end
      end
      default: begin
        res.status = ST_ADDR_ERR;
      end
    endcase
    wen = wen && p_v_r && out_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      if (p_load) begin
        p_v_r <= in_valid;
      end
      if (out_adv) begin
        out_v_r <= p_v_r;
      end
      if (wen) begin
        vld_r[p_addr_r] <= 1'b1;
      end
    end
  end

  // Table RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[p_addr_r] <= wdata;
    end
    if (p_load) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_item_r     <= in_data;
      p_addr_r     <= rd_addr;
      p_in_range_r <= vpn_in < limit;
      p_idx_ok_r   <= idx_in < 32'(TABLE_DEPTH);
      vld_hit_r    <= vld_r[rd_addr];
      // A write-back in this same cycle is not yet in the RAM read data.
      fwd_r        <= wen && (p_addr_r == rd_addr);
      fwd_data_r   <= wdata;
    end
    if (out_adv) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== rtl/lpt_checker.sv =====
// Port-level checks for the linear page table translator, bound to the top level.
module lpt_port_checks
  import lpt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input lpt_in_t     in_data,
  input logic        out_valid,
  input logic        out_stall,
  input lpt_out_t    out_data
);

  // The result side must come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request beat changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");

  // Only a successful translate carries a physical address.
  a_phys_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.phys_addr == 32'd0)
    else $error("physical address on a failed request");

  // A result never carries both a translation and entry read-back fields.
  a_phys_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.phys_addr != 32'd0 |->
      out_data.out_ppn == 16'd0 && !out_data.out_read_ok && !out_data.out_write_ok &&
      !out_data.out_valid && !out_data.out_used && !out_data.out_modified)
    else $error("translate result mixed with entry read-back");

endmodule

bind linear_page_table_translator_top lpt_port_checks u_lpt_port_checks (.*);
